@@ rtl/point_segment_dist_sq_3d_macros.svh @@
// Assertion macros used by the point-to-segment distance checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POINT_SEGMENT_DIST_SQ_3D_MACROS_SVH
`define POINT_SEGMENT_DIST_SQ_3D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSD3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psd3 check failed");

// Consequent must hold in the cycle after the antecedent.
`define PSD3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psd3 check failed");

`endif

@@ rtl/psd3_pkg.sv @@
// Shared widths, codes and pipeline types for the point-to-segment distance block.
// No dependencies; the other sources but the macro header refer to it by scoped names.
package psd3_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;   // difference of two coordinates
    localparam int PROD_W     = 2 * DIFF_W;       // signed product of two differences
    localparam int SQ_W       = 2 * COORD_BITS;   // square of one difference
    localparam int SUM_W      = SQ_W + 2;         // sum of three squares
    localparam int T_W        = SUM_W + 1;        // signed dot product
    localparam int HALF_W     = SUM_W / 2;        // split of t for squaring
    localparam int TSQ_W      = 2 * SUM_W;        // t squared
    localparam int DIST_W     = 34;
    localparam int RES_W      = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic        [SQ_W-1:0]       sq_t;
    typedef logic        [SUM_W-1:0]      sum_t;
    typedef logic signed [T_W-1:0]        dot_t;
    typedef logic        [TSQ_W-1:0]      tsq_t;
    typedef logic        [DIST_W-1:0]     dist_t;
    typedef logic        [RES_W-1:0]      res_t;

    localparam dist_t DIST_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 0,
        REG_START_Y = 1,
        REG_START_Z = 2,
        REG_END_X   = 3,
        REG_END_Y   = 4,
        REG_END_Z   = 5
    } cfg_reg_t;

    // Nearest feature of the segment
    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    // Data that rides along the divider untouched
    typedef struct packed {
        region_t region;
        sum_t    ap2;       // |AP|^2
        sum_t    end_res;   // result for the two endpoint regions
    } side_t;

    // One beat inside the divider
    typedef struct packed {
        sum_t  rem;     // partial remainder, below den
        sum_t  dvd_lo;  // dividend bits still to shift in, msb first
        sum_t  quo;     // quotient bits so far
        sum_t  den;     // divisor |AB|^2
        side_t side;
    } div_stage_t;

endpackage

@@ rtl/psd3_if.sv @@
// Valid/ready channel interfaces for query points and distance results.
// Depends on psd3_pkg for the field widths.
interface psd3_point_if;
    logic               valid;
    logic               ready;
    psd3_pkg::coord_t   point_x;
    psd3_pkg::coord_t   point_y;
    psd3_pkg::coord_t   point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface psd3_result_if;
    logic                   valid;
    logic                   ready;
    logic [psd3_pkg::DIST_W-1:0] dist_sq;
    logic [1:0]             region;

    modport source (output valid, output dist_sq, output region, input ready);
    modport sink   (input valid, input dist_sq, input region, output ready);
endinterface

@@ rtl/point_segment_dist_sq_3d.sv @@
// Channel   | dir | beat contents
// ----------+-----+-------------------------------------------
// point     | in  | point_x, point_y, point_z (signed)
// result    | out | dist_sq (34b, rounded down), region
// cfg_*     | in  | write enable, register index, coordinate
//
// One beat is taken per cycle while no result waits at the output; t^2 / |AB|^2
// is formed by the SUM_W-stage radix-2 divider.
// Reset clears all valid bits and loads A = (0,0,0), B = (1,0,0).
// A result held at the output freezes every stage at once; nothing is lost.
// Depends on psd3_pkg, psd3_if and psd3_div_pipe.
module point_segment_dist_sq_3d (
    input  logic                              clk,
    input  logic                              rst_n,
    psd3_point_if.sink                        point,
    psd3_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [psd3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psd3_pkg::COORD_BITS-1:0]   cfg_wdata
);

    // Segment endpoint registers
    psd3_pkg::coord_t seg_a_reg [3];
    psd3_pkg::coord_t seg_b_reg [3];

    logic adv;

    // Stage 1: differences
    logic              s1_vld_reg;
    psd3_pkg::coord_t  pt [3];
    psd3_pkg::diff_t   s1_ap_next [3], s1_bp_next [3], s1_ab_next [3];
    psd3_pkg::diff_t   s1_ap_reg  [3], s1_bp_reg  [3], s1_ab_reg  [3];

    // Stage 2: products
    logic              s2_vld_reg;
    psd3_pkg::prod_t   ap_sq_full [3], bp_sq_full [3], ab_sq_full [3];
    psd3_pkg::prod_t   s2_dot_next [3];
    psd3_pkg::sq_t     s2_apsq_reg [3], s2_bpsq_reg [3], s2_absq_reg [3];
    psd3_pkg::prod_t   s2_dot_reg  [3];

    // Stage 3: sums
    logic              s3_vld_reg;
    psd3_pkg::sum_t    s3_ap2_next, s3_bp2_next, s3_d_next;
    psd3_pkg::dot_t    s3_t_next;
    psd3_pkg::sum_t    s3_ap2_reg, s3_bp2_reg, s3_d_reg;
    psd3_pkg::dot_t    s3_t_reg;

    // Stage 4: classification
    logic              s4_vld_reg;
    psd3_pkg::side_t   s4_side_next, s4_side_reg;
    psd3_pkg::sum_t    s4_t_reg, s4_d_reg;
    logic              t_neg, t_zero;

    // Stage 5: partial products of t^2
    logic              s5_vld_reg;
    psd3_pkg::sum_t    s5_hh_next, s5_hl_next, s5_ll_next;
    psd3_pkg::sum_t    s5_hh_reg, s5_hl_reg, s5_ll_reg, s5_d_reg;
    psd3_pkg::side_t   s5_side_reg;

    // Stage 6: t^2 and divider load
    logic                  div_in_vld_reg;
    psd3_pkg::tsq_t        t2_next;
    psd3_pkg::div_stage_t  div_in_next, div_in_reg;

    // Divider output and final stage
    logic                  div_out_vld;
    psd3_pkg::div_stage_t  div_out;
    psd3_pkg::sum_t        interior_res, sel_res;
    psd3_pkg::res_t        res_ext;
    psd3_pkg::dist_t       dist_next;
    logic                  out_vld_reg;
    psd3_pkg::dist_t       out_dist_reg;
    psd3_pkg::region_t     out_region_reg;

    // Hold every stage while the output beat waits
    assign adv         = !out_vld_reg || result.ready;
    assign point.ready = adv;

    // Write endpoint registers; drop writes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_a_reg[0] <= '0;
            seg_a_reg[1] <= '0;
            seg_a_reg[2] <= '0;
            seg_b_reg[0] <= psd3_pkg::coord_t'(1);
            seg_b_reg[1] <= '0;
            seg_b_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (psd3_pkg::cfg_reg_t'(cfg_index))
                psd3_pkg::REG_START_X: seg_a_reg[0] <= psd3_pkg::coord_t'(cfg_wdata);
                psd3_pkg::REG_START_Y: seg_a_reg[1] <= psd3_pkg::coord_t'(cfg_wdata);
                psd3_pkg::REG_START_Z: seg_a_reg[2] <= psd3_pkg::coord_t'(cfg_wdata);
                psd3_pkg::REG_END_X:   seg_b_reg[0] <= psd3_pkg::coord_t'(cfg_wdata);
                psd3_pkg::REG_END_Y:   seg_b_reg[1] <= psd3_pkg::coord_t'(cfg_wdata);
                psd3_pkg::REG_END_Z:   seg_b_reg[2] <= psd3_pkg::coord_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Stage 1: AP, BP, AB
    always_comb
    begin
        pt[0] = point.point_x;
        pt[1] = point.point_y;
        pt[2] = point.point_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_ap_next[i] = psd3_pkg::diff_t'(pt[i]) - psd3_pkg::diff_t'(seg_a_reg[i]);
            s1_bp_next[i] = psd3_pkg::diff_t'(pt[i]) - psd3_pkg::diff_t'(seg_b_reg[i]);
            s1_ab_next[i] = psd3_pkg::diff_t'(seg_b_reg[i]) - psd3_pkg::diff_t'(seg_a_reg[i]);
        end
    end

    // Stage 2: squares and dot product terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ap_sq_full[i]  = s1_ap_reg[i] * s1_ap_reg[i];
            bp_sq_full[i]  = s1_bp_reg[i] * s1_bp_reg[i];
            ab_sq_full[i]  = s1_ab_reg[i] * s1_ab_reg[i];
            s2_dot_next[i] = s1_ap_reg[i] * s1_ab_reg[i];
        end
    end

    // Stage 3: sum the three axes
    always_comb
    begin
        s3_ap2_next = psd3_pkg::sum_t'(s2_apsq_reg[0]) + psd3_pkg::sum_t'(s2_apsq_reg[1])
                    + psd3_pkg::sum_t'(s2_apsq_reg[2]);
        s3_bp2_next = psd3_pkg::sum_t'(s2_bpsq_reg[0]) + psd3_pkg::sum_t'(s2_bpsq_reg[1])
                    + psd3_pkg::sum_t'(s2_bpsq_reg[2]);
        s3_d_next   = psd3_pkg::sum_t'(s2_absq_reg[0]) + psd3_pkg::sum_t'(s2_absq_reg[1])
                    + psd3_pkg::sum_t'(s2_absq_reg[2]);
        s3_t_next   = psd3_pkg::dot_t'(s2_dot_reg[0]) + psd3_pkg::dot_t'(s2_dot_reg[1])
                    + psd3_pkg::dot_t'(s2_dot_reg[2]);
    end

    // Stage 4: pick the nearest feature; a degenerate segment lands on the start
    always_comb
    begin
        t_neg  = s3_t_reg[psd3_pkg::T_W-1];
        t_zero = (s3_t_reg == '0);
        s4_side_next.ap2 = s3_ap2_reg;
        if (t_neg || t_zero)
        begin
            s4_side_next.region  = psd3_pkg::REGION_START;
            s4_side_next.end_res = s3_ap2_reg;
        end
        else if (s3_t_reg[psd3_pkg::SUM_W-1:0] >= s3_d_reg)
        begin
            s4_side_next.region  = psd3_pkg::REGION_END;
            s4_side_next.end_res = s3_bp2_reg;
        end
        else
        begin
            s4_side_next.region  = psd3_pkg::REGION_INTERIOR;
            s4_side_next.end_res = s3_ap2_reg;
        end
    end

    // Stage 5: t^2 as three half-width products
    always_comb
    begin
        s5_hh_next = s4_t_reg[psd3_pkg::SUM_W-1:psd3_pkg::HALF_W]
                   * s4_t_reg[psd3_pkg::SUM_W-1:psd3_pkg::HALF_W];
        s5_hl_next = s4_t_reg[psd3_pkg::SUM_W-1:psd3_pkg::HALF_W]
                   * s4_t_reg[psd3_pkg::HALF_W-1:0];
        s5_ll_next = s4_t_reg[psd3_pkg::HALF_W-1:0] * s4_t_reg[psd3_pkg::HALF_W-1:0];
    end

    // Stage 6: assemble t^2 and load the divider; top half is already below d
    always_comb
    begin
        t2_next = (psd3_pkg::tsq_t'(s5_hh_reg) << psd3_pkg::SUM_W)
                + (psd3_pkg::tsq_t'(s5_hl_reg) << (psd3_pkg::HALF_W + 1))
                + psd3_pkg::tsq_t'(s5_ll_reg);
        div_in_next.rem    = t2_next[psd3_pkg::TSQ_W-1:psd3_pkg::SUM_W];
        div_in_next.dvd_lo = t2_next[psd3_pkg::SUM_W-1:0];
        div_in_next.quo    = '0;
        div_in_next.den    = s5_d_reg;
        div_in_next.side   = s5_side_reg;
    end

    // Advance front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_vld_reg     <= 1'b0;
            s4_vld_reg     <= 1'b0;
            s5_vld_reg     <= 1'b0;
            div_in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg     <= point.valid;
            s2_vld_reg     <= s1_vld_reg;
            s3_vld_reg     <= s2_vld_reg;
            s4_vld_reg     <= s3_vld_reg;
            s5_vld_reg     <= s4_vld_reg;
            div_in_vld_reg <= s5_vld_reg;
        end
    end

    // Advance front-end payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_ap_reg[i]   <= s1_ap_next[i];
                s1_bp_reg[i]   <= s1_bp_next[i];
                s1_ab_reg[i]   <= s1_ab_next[i];
                s2_apsq_reg[i] <= ap_sq_full[i][psd3_pkg::SQ_W-1:0];
                s2_bpsq_reg[i] <= bp_sq_full[i][psd3_pkg::SQ_W-1:0];
                s2_absq_reg[i] <= ab_sq_full[i][psd3_pkg::SQ_W-1:0];
                s2_dot_reg[i]  <= s2_dot_next[i];
            end
            s3_ap2_reg  <= s3_ap2_next;
            s3_bp2_reg  <= s3_bp2_next;
            s3_d_reg    <= s3_d_next;
            s3_t_reg    <= s3_t_next;
            s4_side_reg <= s4_side_next;
            s4_t_reg    <= s3_t_reg[psd3_pkg::SUM_W-1:0];
            s4_d_reg    <= s3_d_reg;
            s5_hh_reg   <= s5_hh_next;
            s5_hl_reg   <= s5_hl_next;
            s5_ll_reg   <= s5_ll_next;
            s5_d_reg    <= s4_d_reg;
            s5_side_reg <= s4_side_reg;
            div_in_reg  <= div_in_next;
        end
    end

    psd3_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (div_in_vld_reg),
        .in_stage  (div_in_reg),
        .out_vld   (div_out_vld),
        .out_stage (div_out)
    );

    // Final: |AP|^2 - ceil(t^2/d), select by region, saturate
    always_comb
    begin
        interior_res = div_out.side.ap2 - div_out.quo
                     - psd3_pkg::sum_t'(|div_out.rem);
        if (div_out.side.region == psd3_pkg::REGION_INTERIOR)
        begin
            sel_res = interior_res;
        end
        else
        begin
            sel_res = div_out.side.end_res;
        end
        res_ext = psd3_pkg::res_t'(sel_res);
        if (res_ext > psd3_pkg::res_t'(psd3_pkg::DIST_MAX))
        begin
            dist_next = psd3_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = res_ext[psd3_pkg::DIST_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= div_out_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_dist_reg   <= dist_next;
            out_region_reg <= div_out.side.region;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.dist_sq = out_dist_reg;
    assign result.region  = out_region_reg;

endmodule

@@ rtl/psd3_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, SUM_W stages.
// Depends on psd3_pkg for div_stage_t; stalls with the shared advance enable.
module psd3_div_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_vld,
    input  psd3_pkg::div_stage_t in_stage,
    output logic                 out_vld,
    output psd3_pkg::div_stage_t out_stage
);

    logic                 vld_reg   [psd3_pkg::SUM_W];
    psd3_pkg::div_stage_t stage_reg [psd3_pkg::SUM_W];
    psd3_pkg::div_stage_t stage_prev[psd3_pkg::SUM_W];
    psd3_pkg::div_stage_t stage_next[psd3_pkg::SUM_W];

    // Shift in one dividend bit, subtract the divisor when it fits
    function automatic psd3_pkg::div_stage_t div_step(psd3_pkg::div_stage_t cur);
        logic [psd3_pkg::SUM_W:0]   shifted;
        logic [psd3_pkg::SUM_W+1:0] diff;
        logic                       take;
        psd3_pkg::div_stage_t       nxt;
        nxt     = cur;
        shifted = {cur.rem, cur.dvd_lo[psd3_pkg::SUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, cur.den};
        take    = !diff[psd3_pkg::SUM_W+1];
        nxt.rem    = take ? diff[psd3_pkg::SUM_W-1:0] : shifted[psd3_pkg::SUM_W-1:0];
        nxt.dvd_lo = {cur.dvd_lo[psd3_pkg::SUM_W-2:0], 1'b0};
        nxt.quo    = {cur.quo[psd3_pkg::SUM_W-2:0], take};
        return nxt;
    endfunction

    // Feed each stage from the one before it
    always_comb
    begin
        stage_prev[0] = in_stage;
        for (int k = 1; k < psd3_pkg::SUM_W; k++)
        begin
            stage_prev[k] = stage_reg[k-1];
        end
        for (int k = 0; k < psd3_pkg::SUM_W; k++)
        begin
            stage_next[k] = div_step(stage_prev[k]);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < psd3_pkg::SUM_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < psd3_pkg::SUM_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < psd3_pkg::SUM_W; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_vld   = vld_reg[psd3_pkg::SUM_W-1];
    assign out_stage = stage_reg[psd3_pkg::SUM_W-1];

endmodule

@@ rtl/psd3_checker.sv @@
// Port-level checks for point_segment_dist_sq_3d, attached by bind.
// Depends on point_segment_dist_sq_3d_macros.svh and psd3_pkg.
`include "point_segment_dist_sq_3d_macros.svh"

module psd3_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        point_valid,
    input logic                        point_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [psd3_pkg::DIST_W-1:0] dist_sq,
    input logic [1:0]                  region
);

    // A stalled result beat stays offered
    `PSD3_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)

    // A stalled result beat keeps its payload
    `PSD3_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(dist_sq) && $stable(region))

    // A waiting result freezes the whole pipe, so no point beat is taken
    `PSD3_ASSERT_NOW(a_stall_blocks_input, result_valid && !result_ready, !point_ready)

    // An empty output stage lets the pipe advance
    `PSD3_ASSERT_NOW(a_empty_takes_input, !result_valid, point_ready)

endmodule

bind point_segment_dist_sq_3d psd3_checker u_psd3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .dist_sq      (result.dist_sq),
    .region       (result.region)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for point_segment_dist_sq_3d: random and directed query points,
// segment loads through the register port, results checked against an in-bench model.
// Depends on psd3_pkg, psd3_if and the RTL of the block.
module tb_top;

    localparam psd3_pkg::coord_t COORD_LO = {1'b1, {(psd3_pkg::COORD_BITS-1){1'b0}}};
    localparam psd3_pkg::coord_t COORD_HI = ~COORD_LO;
    localparam logic [psd3_pkg::CFG_IDX_W-1:0] IDX_PAST_END =
        psd3_pkg::CFG_IDX_W'(psd3_pkg::NUM_REGS);
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        psd3_pkg::coord_t x;
        psd3_pkg::coord_t y;
        psd3_pkg::coord_t z;
    } point_beat_t;

    typedef struct packed {
        psd3_pkg::dist_t   dist_sq;
        psd3_pkg::region_t region;
    } dist_beat_t;

    typedef psd3_pkg::coord_t seg_regs_t [psd3_pkg::NUM_REGS];

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [psd3_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psd3_pkg::COORD_BITS-1:0] cfg_wdata;

    psd3_point_if  point_ch ();
    psd3_result_if result_ch ();

    point_segment_dist_sq_3d uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Bench copy of the segment registers
    psd3_pkg::coord_t seg_coord [psd3_pkg::NUM_REGS];
    point_beat_t points_to_send [$];
    dist_beat_t  dist_expected [$];
    point_beat_t next_point;
    dist_beat_t  want;
    int          send_gap;
    int          hold_left;
    int          in_style;
    int          out_style;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Exact squared distance for the current segment
    function automatic dist_beat_t segment_distance(point_beat_t p);
        longint       pt [3];
        longint       ap [3];
        longint       bp [3];
        longint       ab [3];
        longint       dot;
        longint       ap_sq;
        longint       bp_sq;
        longint       len_sq;
        logic [127:0] dot_sq;
        logic [127:0] ceil_q;
        logic [127:0] res;
        dist_beat_t   r;
        pt[0] = longint'($signed(p.x));
        pt[1] = longint'($signed(p.y));
        pt[2] = longint'($signed(p.z));
        dot = 0;
        ap_sq = 0;
        bp_sq = 0;
        len_sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            ap[i] = pt[i] - longint'(seg_coord[i]);
            bp[i] = pt[i] - longint'(seg_coord[i + 3]);
            ab[i] = longint'(seg_coord[i + 3]) - longint'(seg_coord[i]);
            dot += ap[i] * ab[i];
            ap_sq += ap[i] * ap[i];
            bp_sq += bp[i] * bp[i];
            len_sq += ab[i] * ab[i];
        end
        if (dot <= 0)
        begin
            res = 128'(ap_sq);
            r.region = psd3_pkg::REGION_START;
        end
        else if (dot >= len_sq)
        begin
            res = 128'(bp_sq);
            r.region = psd3_pkg::REGION_END;
        end
        else
        begin
            // floor of the exact value equals |AP|^2 minus ceil(t^2 / d)
            dot_sq = 128'(dot) * 128'(dot);
            ceil_q = (dot_sq + 128'(len_sq) - 128'd1) / 128'(len_sq);
            res = 128'(ap_sq) - ceil_q;
            r.region = psd3_pkg::REGION_INTERIOR;
        end
        r.dist_sq = (res > 128'(psd3_pkg::DIST_MAX)) ? psd3_pkg::DIST_MAX
                                                     : res[psd3_pkg::DIST_W-1:0];
        return r;
    endfunction

    // Gap length: style 0 none, 1 mostly short, 2 heavy
    function automatic int pick_gap(int style);
        int r;
        r = $urandom_range(0, 99);
        if (style == 0)
            return 0;
        if (style == 1)
        begin
            if (r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
        if (r < 30)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic void flag_mismatch(string what, longint unsigned exp_v,
                                          longint unsigned act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR %0t: %s expected %0d actual %0d", $realtime, what, exp_v, act_v);
    endfunction

    function automatic psd3_pkg::coord_t clamp_coord(longint v);
        if (v < longint'(COORD_LO))
            return COORD_LO;
        if (v > longint'(COORD_HI))
            return COORD_HI;
        return psd3_pkg::coord_t'(v);
    endfunction

    function automatic psd3_pkg::coord_t random_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return COORD_LO;
        if (r == 1)
            return COORD_HI;
        return psd3_pkg::coord_t'($urandom);
    endfunction

    // Mix far points, points near either end and points along the segment
    function automatic point_beat_t random_point();
        int          kind;
        int          step;
        int          spread;
        longint      c [3];
        point_beat_t p;
        kind = $urandom_range(0, 99);
        step = $urandom_range(0, 16);
        spread = ($urandom_range(0, 3) == 0) ? 2000 : 64;
        for (int i = 0; i < 3; i++)
        begin
            if (kind < 35)
                c[i] = longint'(random_coord());
            else if (kind < 50)
                c[i] = longint'(seg_coord[i]) + int'($urandom_range(0, 8)) - 4;
            else if (kind < 65)
                c[i] = longint'(seg_coord[i + 3]) + int'($urandom_range(0, 8)) - 4;
            else
                c[i] = longint'(seg_coord[i])
                     + (longint'(seg_coord[i + 3]) - longint'(seg_coord[i])) * step / 16
                     + int'($urandom_range(0, 2 * spread)) - spread;
        end
        p.x = clamp_coord(c[0]);
        p.y = clamp_coord(c[1]);
        p.z = clamp_coord(c[2]);
        return p;
    endfunction

    task automatic push_point(psd3_pkg::coord_t x, psd3_pkg::coord_t y, psd3_pkg::coord_t z);
        points_to_send.push_back('{x: x, y: y, z: z});
    endtask

    // Write all six registers back to back, then release the port
    task automatic load_segment(seg_regs_t vals);
        for (int i = 0; i < psd3_pkg::NUM_REGS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= psd3_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every point is sent and every result is back
    task automatic drain();
        do
            @(negedge clk);
        while (points_to_send.size() != 0 || point_ch.valid || dist_expected.size() != 0);
    endtask

    // Track register writes as the block sees them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psd3_pkg::NUM_REGS; i++)
                seg_coord[i] <= '0;
            seg_coord[psd3_pkg::REG_END_X] <= psd3_pkg::coord_t'(1);
        end
        else if (cfg_we && cfg_index < psd3_pkg::NUM_REGS)
        begin
            seg_coord[cfg_index] <= cfg_wdata;
        end
    end

    // Point driver: predict on each accepted beat, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
                dist_expected.push_back(segment_distance('{x: point_ch.point_x,
                                                           y: point_ch.point_y,
                                                           z: point_ch.point_z}));
            if (!point_ch.valid || point_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    point_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (points_to_send.size() != 0)
                begin
                    next_point = points_to_send.pop_front();
                    point_ch.point_x <= next_point.x;
                    point_ch.point_y <= next_point.y;
                    point_ch.point_z <= next_point.z;
                    point_ch.valid <= 1'b1;
                    send_gap <= pick_gap(in_style);
                end
                else
                begin
                    point_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (dist_expected.size() == 0)
                begin
                    flag_mismatch("result with nothing pending, dist_sq", 0, result_ch.dist_sq);
                end
                else
                begin
                    want = dist_expected.pop_front();
                    if (result_ch.dist_sq !== want.dist_sq)
                        flag_mismatch("dist_sq", want.dist_sq, result_ch.dist_sq);
                    if (result_ch.region !== want.region)
                        flag_mismatch("region", want.region, result_ch.region);
                end
            end
            // Stall the result side in random stretches
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                hold_left <= pick_gap(out_style);
            end
        end
    end

    // Count cycles without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("point_segment_dist_sq_3d: mismatch");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        seg_regs_t seg;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        point_ch.valid = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        result_ch.ready = 1'b0;
        in_style = 0;
        out_style = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset segment: projections on both ends, far corners, both sides
        push_point(0, 0, 0);
        push_point(1, 0, 0);
        push_point(COORD_HI, COORD_HI, COORD_HI);
        push_point(COORD_LO, COORD_LO, COORD_LO);
        push_point(COORD_LO, COORD_HI, COORD_LO);
        push_point(-1, 5, -5);
        push_point(2, 3, 4);
        drain();

        // Degenerate segment, then the largest distance there is
        in_style = 1;
        out_style = 1;
        load_segment('{5, -7, 3, 5, -7, 3});
        push_point(5, -7, 3);
        push_point(COORD_HI, COORD_HI, COORD_HI);
        push_point(COORD_LO, COORD_LO, COORD_LO);
        drain();
        load_segment('{COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO});
        push_point(COORD_HI, COORD_HI, COORD_HI);
        drain();

        // Full-range diagonal segment
        load_segment('{COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI});
        push_point(0, 0, 0);
        push_point(COORD_LO, COORD_HI, COORD_LO);
        push_point(COORD_HI, COORD_LO, COORD_HI);
        push_point(COORD_LO, COORD_LO, COORD_LO);
        push_point(COORD_HI, COORD_HI, COORD_HI);
        push_point(COORD_HI, COORD_LO, COORD_LO);
        drain();

        // Short segment with an inexact interior quotient; writes past the
        // last register must leave it untouched
        load_segment('{0, 0, 0, 2, 1, 0});
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= IDX_PAST_END;
        cfg_wdata <= psd3_pkg::COORD_BITS'($urandom);
        @(posedge clk);
        cfg_index <= IDX_PAST_END + 1'b1;
        cfg_wdata <= psd3_pkg::COORD_BITS'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        push_point(1, 1, 1);
        push_point(2, 1, 0);
        push_point(0, 0, 0);
        push_point(1, 0, 0);
        push_point(-1, -1, 5);
        push_point(3, 1, 0);
        drain();

        // Random phases, each on its own segment
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < psd3_pkg::NUM_REGS; i++)
            begin
                case (ph)
                    1, 7:    seg[i] = psd3_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
                    5:       seg[i] = $urandom_range(0, 1) ? COORD_HI : COORD_LO;
                    default: seg[i] = random_coord();
                endcase
            end
            // Degenerate and axis-aligned segments
            if (ph == 3)
            begin
                for (int i = 0; i < 3; i++)
                    seg[i + 3] = seg[i];
            end
            else if (ph == 4)
            begin
                for (int i = 0; i < 3; i++)
                    seg[i + 3] = seg[i];
                seg[3 + $urandom_range(0, 2)] = random_coord();
            end
            load_segment(seg);
            in_style = (ph == 6) ? 0 : (ph == 7) ? 2 : 1;
            out_style = (ph == 6) ? 0 : (ph == 2 || ph == 7) ? 2 : 1;
            repeat (172) points_to_send.push_back(random_point());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dist_expected.size() != 0)
            flag_mismatch("results never delivered", dist_expected.size(), 0);
        if (mismatches == 0)
            $display("point_segment_dist_sq_3d: match");
        else
            $display("point_segment_dist_sq_3d: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/psd3_pkg.sv
rtl/psd3_if.sv
rtl/psd3_div_pipe.sv
rtl/point_segment_dist_sq_3d.sv
rtl/psd3_checker.sv
sim/tb_top.sv
